@@ sv/sst_pkg.sv @@
// Shared constants, payload types and memory port bundles for the sorted sibling table.
`default_nettype none
package sst_pkg;

    localparam int CAPACITY   = 256;
    localparam int CODE_BITS  = 16;
    localparam int RANK_BITS  = 16;
    localparam int CHILD_BITS = 31;

    // fixed widths of the payload fields
    localparam int OP_W    = 3;
    localparam int POS_W   = 9;
    localparam int CODE_W  = 16;
    localparam int CHILD_W = 31;
    localparam int RANK_W  = 16;

    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int CMP_BITS  = (CNT_BITS > POS_W) ? CNT_BITS : POS_W;
    localparam int MAP_DEPTH = 2 ** CODE_BITS;

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_MARK_LEAF = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd2;
    localparam logic [OP_W-1:0] OP_READ      = 3'd3;
    localparam logic [OP_W-1:0] OP_WRITE_MAP = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [POS_W-1:0]   position;
        logic [CODE_W-1:0]  char_code;
        logic               leaf_in;
        logic [CHILD_W-1:0] child_in;
        logic [RANK_W-1:0]  rank_in;
    } t_in;

    typedef struct packed {
        logic               ok;
        logic               found;
        logic [POS_W-1:0]   where;
        logic [CHILD_W-1:0] child_out;
        logic [CODE_W-1:0]  code_out;
        logic               leaf_out;
        logic [POS_W-1:0]   entry_count;
    } t_out;

    typedef struct packed {
        logic [CODE_BITS-1:0]  code;
        logic                  leaf;
        logic [CHILD_BITS-1:0] child;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        t_entry               wdata;
        logic [ADDR_BITS-1:0] raddr;
    } t_ent_req;

    typedef struct packed {
        logic                 we;
        logic [CODE_BITS-1:0] waddr;
        logic [RANK_BITS-1:0] wdata;
        logic [CODE_BITS-1:0] raddr;
    } t_map_req;

endpackage
`default_nettype wire

@@ sv/sst_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ sv/sst_seq.sv @@
// Sequencer: decodes one word, shifts entries on insert, runs the binary search probe loop.
`default_nettype none
module sst_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire sst_pkg::t_in                  i_in,
    output sst_pkg::t_ent_req                  o_ent_req,
    input  wire sst_pkg::t_entry               i_ent_rdata,
    output sst_pkg::t_map_req                  o_map_req,
    input  wire logic [sst_pkg::RANK_BITS-1:0] i_map_rdata,
    output logic                               o_res_valid,
    output sst_pkg::t_out                      o_res,
    input  wire logic                          i_res_take
);
    import sst_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DONE   = 10'b0000000010,
        S_SH_RD  = 10'b0000000100,
        S_SH_WR  = 10'b0000001000,
        S_INS_WR = 10'b0000010000,
        S_ML_WR  = 10'b0000100000,
        S_RD_OUT = 10'b0001000000,
        S_F_KEY  = 10'b0010000000,
        S_F_ENT  = 10'b0100000000,
        S_F_CMP  = 10'b1000000000
    } t_state;

    typedef enum logic [2:0] {
        P_FIRST = 3'b001,
        P_LAST  = 3'b010,
        P_BIN   = 3'b100
    } t_phase;

    localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);

    t_state                r_state, n_state;
    t_phase                r_phase, n_phase;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [ADDR_BITS-1:0]  r_pos, n_pos;
    logic [ADDR_BITS-1:0]  r_idx, n_idx;
    t_entry                r_new, n_new;
    logic [RANK_BITS-1:0]  r_key, n_key;
    logic [CNT_BITS-1:0]   r_lo, n_lo;
    logic [CNT_BITS-1:0]   r_hi, n_hi;
    logic [CNT_BITS-1:0]   r_mid, n_mid;
    logic [CHILD_BITS-1:0] r_pchild, n_pchild;
    t_out                  r_res, n_res;

    logic [ADDR_BITS-1:0]  idx_dec;
    logic [CNT_BITS-1:0]   last;
    logic                  pos_in_table;
    logic                  key_eq;
    logic                  key_lt;

    function automatic logic [CNT_BITS-1:0] mid_of(input logic [CNT_BITS-1:0] lo,
                                                   input logic [CNT_BITS-1:0] hi);
        logic [CNT_BITS-1:0] span;
        span = hi - lo - CNT_ONE;
        return lo + (span >> 1);
    endfunction

    assign idx_dec      = r_idx - ADDR_BITS'(1);
    assign last         = r_count - CNT_ONE;
    assign pos_in_table = CMP_BITS'(i_in.position) < CMP_BITS'(r_count);
    assign key_eq       = r_key == i_map_rdata;
    assign key_lt       = r_key < i_map_rdata;

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_count  = r_count;
        n_pos    = r_pos;
        n_idx    = r_idx;
        n_new    = r_new;
        n_key    = r_key;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_pchild = r_pchild;
        n_res    = r_res;
        o_ent_req   = '0;
        o_map_req   = '0;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    n_pos   = ADDR_BITS'(i_in.position);
                    unique case (i_in.op)
                        OP_INSERT: begin
                            if (CMP_BITS'(i_in.position) <= CMP_BITS'(r_count)
                                && r_count < CNT_BITS'(CAPACITY)) begin
                                n_new.code  = CODE_BITS'(i_in.char_code);
                                n_new.leaf  = i_in.leaf_in;
                                n_new.child = CHILD_BITS'(i_in.child_in);
                                n_idx       = ADDR_BITS'(r_count);
                                n_state     = (CMP_BITS'(i_in.position) == CMP_BITS'(r_count))
                                              ? S_INS_WR : S_SH_RD;
                            end
                        end
                        OP_MARK_LEAF: begin
                            if (pos_in_table) begin
                                o_ent_req.raddr = ADDR_BITS'(i_in.position);
                                n_state         = S_ML_WR;
                            end
                        end
                        OP_READ: begin
                            if (pos_in_table) begin
                                o_ent_req.raddr = ADDR_BITS'(i_in.position);
                                n_state         = S_RD_OUT;
                            end
                        end
                        OP_FIND: begin
                            n_res.ok = 1'b1;
                            if (r_count != '0) begin
                                o_map_req.raddr = CODE_BITS'(i_in.char_code);
                                n_state         = S_F_KEY;
                            end
                        end
                        OP_WRITE_MAP: begin
                            o_map_req.we    = 1'b1;
                            o_map_req.waddr = CODE_BITS'(i_in.char_code);
                            o_map_req.wdata = RANK_BITS'(i_in.rank_in);
                            n_res.ok        = 1'b1;
                        end
                        default: begin
                            n_res.ok = 1'b0;
                        end
                    endcase
                end
            end

            // shift one entry up: read below, then write at r_idx
            S_SH_RD: begin
                o_ent_req.raddr = idx_dec;
                n_state         = S_SH_WR;
            end

            S_SH_WR: begin
                o_ent_req.we    = 1'b1;
                o_ent_req.waddr = r_idx;
                o_ent_req.wdata = i_ent_rdata;
                n_idx           = idx_dec;
                n_state         = (idx_dec == r_pos) ? S_INS_WR : S_SH_RD;
            end

            S_INS_WR: begin
                o_ent_req.we    = 1'b1;
                o_ent_req.waddr = r_pos;
                o_ent_req.wdata = r_new;
                n_count         = r_count + CNT_ONE;
                n_res.ok        = 1'b1;
                n_state         = S_DONE;
            end

            S_ML_WR: begin
                o_ent_req.we         = 1'b1;
                o_ent_req.waddr      = r_pos;
                o_ent_req.wdata      = i_ent_rdata;
                o_ent_req.wdata.leaf = 1'b1;
                n_res.ok             = 1'b1;
                n_state              = S_DONE;
            end

            S_RD_OUT: begin
                n_res.ok        = 1'b1;
                n_res.child_out = CHILD_W'(i_ent_rdata.child);
                n_res.code_out  = CODE_W'(i_ent_rdata.code);
                n_res.leaf_out  = i_ent_rdata.leaf;
                n_state         = S_DONE;
            end

            S_F_KEY: begin
                n_key           = i_map_rdata;
                o_ent_req.raddr = '0;
                n_mid           = '0;
                n_phase         = P_FIRST;
                n_state         = S_F_ENT;
            end

            // entry data back: fetch its rank
            S_F_ENT: begin
                n_pchild        = i_ent_rdata.child;
                o_map_req.raddr = i_ent_rdata.code;
                n_state         = S_F_CMP;
            end

            S_F_CMP: begin
                n_state = S_DONE;
                if (key_eq) begin
                    n_res.found     = 1'b1;
                    n_res.where     = POS_W'(r_mid);
                    n_res.child_out = CHILD_W'(r_pchild);
                end else begin
                    unique case (r_phase)
                        P_FIRST: begin
                            if (key_lt) begin
                                n_res.where = '0;
                            end else if (last == '0) begin
                                n_res.where = POS_W'(1);
                            end else begin
                                n_mid           = last;
                                o_ent_req.raddr = ADDR_BITS'(last);
                                n_phase         = P_LAST;
                                n_state         = S_F_ENT;
                            end
                        end
                        P_LAST: begin
                            if (!key_lt) begin
                                n_res.where = POS_W'(r_count);
                            end else if (CNT_ONE < last) begin
                                n_lo            = CNT_ONE;
                                n_hi            = last;
                                n_mid           = mid_of(CNT_ONE, last);
                                o_ent_req.raddr = ADDR_BITS'(mid_of(CNT_ONE, last));
                                n_phase         = P_BIN;
                                n_state         = S_F_ENT;
                            end else begin
                                // nothing between first and last: goes right after first
                                n_res.where = POS_W'(1);
                            end
                        end
                        P_BIN: begin
                            if (key_lt) begin
                                n_lo = r_lo;
                                n_hi = r_mid;
                            end else begin
                                n_lo = r_mid + CNT_ONE;
                                n_hi = r_hi;
                            end
                            if (n_lo < n_hi) begin
                                n_mid           = mid_of(n_lo, n_hi);
                                o_ent_req.raddr = ADDR_BITS'(mid_of(n_lo, n_hi));
                                n_state         = S_F_ENT;
                            end else begin
                                n_res.where = key_lt ? POS_W'(r_mid) : POS_W'(r_mid + CNT_ONE);
                            end
                        end
                        default: begin
                            n_res.where = '0;
                        end
                    endcase
                end
            end

            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res             = r_res;
        o_res.entry_count = POS_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_FIRST;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_new    <= n_new;
        r_key    <= n_key;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_pchild <= n_pchild;
        r_res    <= n_res;
    end

endmodule
`default_nettype wire

@@ sv/sorted_sibling_table_core.sv @@
// Write rank map, find on an empty table and rejected ops go straight to the result state;
// read and mark leaf read the entry first. Insert at position p with n entries shifts the
// n-p entries above p up one place, each by a read and then a write of the entry RAM.
// Find: a key rank read, then per probe an entry read then a rank read.
// One word at a time: the next word is taken once the result moves to the output register.
// Reset (i_rst_n low, synchronous) empties the table; the rank map keeps its contents.
`default_nettype none
module sorted_sibling_table_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire sst_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output sst_pkg::t_out      o_out_data
);
    import sst_pkg::*;

    t_ent_req             ent_req;
    t_entry               ent_rdata;
    logic [ENTRY_BITS-1:0] ent_rbits;
    t_map_req             map_req;
    logic [RANK_BITS-1:0] map_rdata;
    logic                 res_valid;
    t_out                 res;
    logic                 res_take;
    logic                 r_out_valid;
    t_out                 r_out_data;

    assign res_take  = !r_out_valid || i_out_ready;
    assign ent_rdata = t_entry'(ent_rbits);

    sst_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_in        (i_in_data),
        .o_ent_req   (ent_req),
        .i_ent_rdata (ent_rdata),
        .o_map_req   (map_req),
        .i_map_rdata (map_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    sst_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (CAPACITY)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_req.we),
        .i_waddr (ent_req.waddr),
        .i_wdata (ent_req.wdata),
        .i_raddr (ent_req.raddr),
        .o_rdata (ent_rbits)
    );

    sst_ram #(
        .WIDTH (RANK_BITS),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_req.we),
        .i_waddr (map_req.waddr),
        .i_wdata (map_req.wdata),
        .i_raddr (map_req.raddr),
        .o_rdata (map_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

@@ sv/sst_chk.sv @@
// Port-level checker for the sorted sibling table, bound to the top level.
`default_nettype none
module sst_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire sst_pkg::t_out o_out_data
);
    import sst_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.entry_count <= CAPACITY)
        else $error("entry count above capacity");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.ok |-> !o_out_data.found && o_out_data.where == '0
            && o_out_data.child_out == '0 && o_out_data.code_out == '0
            && !o_out_data.leaf_out)
        else $error("rejected word carries data");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |-> o_out_data.ok
            && o_out_data.where < o_out_data.entry_count)
        else $error("match outside the table");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("ready right after accepting a word");

endmodule

bind sorted_sibling_table_core sst_chk u_sst_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire
